FILE: hdl/rgmm_pkg.sv
// Package for the raster group min/max/mean unit.
// Holds shared widths, code constants and the controller/datapath structs.
// No dependencies.
package rgmm_pkg;

    localparam int MAX_RASTERS_DEF = 64;

    localparam int CELL_W  = 32;
    localparam int TILE_W  = 16;
    localparam int TILES_W = 17;
    localparam int SUM_W   = 64;
    localparam int CNT_W   = 32;
    localparam int RN_W    = 6;
    localparam int WORD_W  = CNT_W + SUM_W + 2 * CELL_W;

    // Divider runs one quotient bit per cycle over the whole sum.
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Action codes of an input word
    localparam logic ACT_CELL   = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    // Order mode codes
    localparam logic MODE_SPATIAL  = 1'b0;
    localparam logic MODE_TEMPORAL = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic take;       // latch a cell word and run tile bookkeeping
        logic rd_cell;    // read the slot of the latched cell
        logic wr_cell;    // write back the updated slot
        logic rpt_start;  // clear the report index
        logic rd_rpt;     // read the slot at the report index
        logic div_start;  // start the mean division
        logic out_load;   // load the output register
        logic rpt_next;   // step the report index
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic used_zero;
        logic rpt_last;
        logic div_done;
        logic div_busy;
        logic out_free;
    } t_sts;

endpackage

FILE: hdl/rgmm_ifs.sv
// Channel interfaces of the raster group min/max/mean unit.
// Cell input, statistics output and order mode configuration.
// No dependencies.
interface rgmm_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [15:0]        tile_index;
    logic [16:0]        tiles_per_raster;
    logic signed [31:0] cell_value;
    logic               last_in_tile;

    modport source (output valid, action, tile_index, tiles_per_raster, cell_value,
                    last_in_tile, input ready);
    modport sink   (input valid, action, tile_index, tiles_per_raster, cell_value,
                    last_in_tile, output ready);
endinterface

interface rgmm_out_if;
    logic               valid;
    logic               ready;
    logic [5:0]         raster_number;
    logic signed [31:0] mean_value;
    logic signed [31:0] maximum_value;
    logic signed [31:0] minimum_value;
    logic               last_entry;
    logic               cells_dropped;

    modport source (output valid, raster_number, mean_value, maximum_value, minimum_value,
                    last_entry, cells_dropped, input ready);
    modport sink   (input valid, raster_number, mean_value, maximum_value, minimum_value,
                    last_entry, cells_dropped, output ready);
endinterface

interface rgmm_cfg_if;
    logic valid;
    logic ready;
    logic order_mode;

    modport source (output valid, order_mode, input ready);
    modport sink   (input valid, order_mode, output ready);
endinterface

FILE: hdl/raster_group_min_max_mean_unit.sv
// Top level of the raster group min/max/mean unit.
// Depends on rgmm_pkg, rgmm_ifs, rgmm_ctrl and rgmm_dp.
//
// Usage:
//   i_cell_ch carries words: a cell (action 0) updates the minimum, maximum,
//   sum and count of its raster slot; a report (action 1) emits one word per
//   slot in use on o_stat_ch, slot 0 first, last_entry on the final one.
//   i_cfg_ch sets order_mode (0 spatial, 1 temporal); it is always ready and
//   is meant to be written only while the unit is idle.
// Operation:
//   A cell word goes through accept, statistics RAM read and write back.
//   A report handles each slot with a RAM read, the bit-serial mean divider
//   (64 steps) and the output load; an empty report is accepted and gives no
//   words.
//   The next input word is accepted once the previous one is done, even while
//   the last statistics word still waits in the output register.
// Reset:
//   i_rst_n (synchronous, active low) clears slot usage, the overflow flag,
//   tile tracking and order_mode; the RAM is not cleared.
// Stall:
//   A report pauses on each word until o_stat_ch.ready takes the previous one.
module raster_group_min_max_mean_unit #(
    parameter int MAX_RASTERS = rgmm_pkg::MAX_RASTERS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rgmm_in_if.sink     i_cell_ch,
    rgmm_cfg_if.sink    i_cfg_ch,
    rgmm_out_if.source  o_stat_ch
);
    import rgmm_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic in_ready;

    assign i_cfg_ch.ready  = 1'b1;
    assign i_cell_ch.ready = in_ready;

    rgmm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cell_ch.valid),
        .i_action   (i_cell_ch.action),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rgmm_dp #(.MAX_RASTERS(MAX_RASTERS)) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_ch.valid),
        .i_cfg_mode         (i_cfg_ch.order_mode),
        .i_tile_index       (i_cell_ch.tile_index),
        .i_tiles_per_raster (i_cell_ch.tiles_per_raster),
        .i_cell_value       (i_cell_ch.cell_value),
        .i_last_in_tile     (i_cell_ch.last_in_tile),
        .i_out_ready        (o_stat_ch.ready),
        .o_out_valid        (o_stat_ch.valid),
        .o_raster_number    (o_stat_ch.raster_number),
        .o_mean_value       (o_stat_ch.mean_value),
        .o_maximum_value    (o_stat_ch.maximum_value),
        .o_minimum_value    (o_stat_ch.minimum_value),
        .o_last_entry       (o_stat_ch.last_entry),
        .o_cells_dropped    (o_stat_ch.cells_dropped)
    );

    // Divider never runs while the unit takes input
    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready |-> !sts.div_busy)
        else $error("divider busy while input ready");

    // A finished division leaves the divider free
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.div_done |-> !sts.div_busy)
        else $error("divider done while still busy");

    // Output is loaded only when the register is free
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("output word overwritten");
endmodule

FILE: hdl/rgmm_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module rgmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/rgmm_div.sv
// Sequential signed-by-unsigned divider, one quotient bit per cycle.
// Depends on rgmm_pkg.
module rgmm_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [rgmm_pkg::SUM_W-1:0]   i_dividend,
    input  logic [rgmm_pkg::CNT_W-1:0]          i_divisor,
    output logic signed [rgmm_pkg::CELL_W-1:0]  o_quot,
    output logic                                o_done,
    output logic                                o_busy
);
    import rgmm_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_neg;
    logic [SUM_W-1:0]     r_q;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_den;
    logic [CNT_W:0]       rem_sh;
    logic                 fits;

    assign rem_sh = {r_rem, r_q[SUM_W-1]};
    assign fits   = rem_sh >= {1'b0, r_den};

    // Control: count down the quotient bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: restoring division on the magnitude
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_q   <= i_dividend[SUM_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[SUM_W-2:0], fits};
            r_rem <= fits ? CNT_W'(rem_sh - {1'b0, r_den}) : rem_sh[CNT_W-1:0];
        end
    end

    assign o_quot = r_neg ? -$signed(r_q[CELL_W-1:0]) : $signed(r_q[CELL_W-1:0]);
    assign o_done = r_done;
    assign o_busy = r_busy;
endmodule

FILE: hdl/rgmm_ctrl.sv
// Controller state machine of the raster group min/max/mean unit.
// Depends on rgmm_pkg.
module rgmm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_action,
    output logic            o_in_ready,
    input  rgmm_pkg::t_sts  i_sts,
    output rgmm_pkg::t_cmd  o_cmd
);
    import rgmm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_CELL_RD, S_CELL_WR, S_RPT_RD, S_RPT_GO, S_RPT_DIV, S_RPT_OUT
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_CELL) begin
                        o_cmd.take = 1'b1;
                        n_state    = S_CELL_RD;
                    end else if (!i_sts.used_zero) begin
                        o_cmd.rpt_start = 1'b1;
                        n_state         = S_RPT_RD;
                    end
                end
            end
            S_CELL_RD: begin
                o_cmd.rd_cell = 1'b1;
                n_state       = S_CELL_WR;
            end
            S_CELL_WR: begin
                o_cmd.wr_cell = 1'b1;
                n_state       = S_IDLE;
            end
            S_RPT_RD: begin
                o_cmd.rd_rpt = 1'b1;
                n_state      = S_RPT_GO;
            end
            S_RPT_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_RPT_DIV;
            end
            S_RPT_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_RPT_OUT;
                end
            end
            S_RPT_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.rpt_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.rpt_next = 1'b1;
                        n_state        = S_RPT_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

FILE: hdl/rgmm_dp.sv
// Datapath of the raster group min/max/mean unit: slot bookkeeping,
// statistics RAM, mean divider and output register.
// Depends on rgmm_pkg, rgmm_ram and rgmm_div.
module rgmm_dp #(
    parameter int MAX_RASTERS = rgmm_pkg::MAX_RASTERS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rgmm_pkg::t_cmd                      i_cmd,
    output rgmm_pkg::t_sts                      o_sts,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_mode,
    input  logic [rgmm_pkg::TILE_W-1:0]         i_tile_index,
    input  logic [rgmm_pkg::TILES_W-1:0]        i_tiles_per_raster,
    input  logic signed [rgmm_pkg::CELL_W-1:0]  i_cell_value,
    input  logic                                i_last_in_tile,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [rgmm_pkg::RN_W-1:0]           o_raster_number,
    output logic signed [rgmm_pkg::CELL_W-1:0]  o_mean_value,
    output logic signed [rgmm_pkg::CELL_W-1:0]  o_maximum_value,
    output logic signed [rgmm_pkg::CELL_W-1:0]  o_minimum_value,
    output logic                                o_last_entry,
    output logic                                o_cells_dropped
);
    import rgmm_pkg::*;

    localparam int SW = $clog2(MAX_RASTERS + 1);
    localparam int AW = (MAX_RASTERS > 1) ? $clog2(MAX_RASTERS) : 1;
    localparam logic [SW-1:0] LIMIT = SW'(MAX_RASTERS);

    // Bookkeeping state
    logic              r_mode;
    logic [SW-1:0]     r_cur;
    logic [TILE_W-1:0] r_prev;
    logic [SW-1:0]     r_used;
    logic              r_ovf;
    logic              r_open;

    // Latched cell
    logic [SW-1:0]      r_slot;
    logic               r_fresh;
    logic               r_drop;
    logic signed [CELL_W-1:0] r_cell;

    // Report
    logic [SW-1:0]            r_k;
    logic signed [CELL_W-1:0] r_min, r_max;

    // Output register
    logic                     r_o_valid;
    logic [RN_W-1:0]          r_o_rn;
    logic signed [CELL_W-1:0] r_o_mean, r_o_max, r_o_min;
    logic                     r_o_last, r_o_drop;

    logic [SW-1:0]   slot_now;
    logic            restart, adv_tile, fresh_now, drop_now;
    logic [SW:0]     k_inc;
    logic [SW+RN_W-1:0] k_wide;

    logic [WORD_W-1:0] rd_word, wr_word;
    logic signed [CELL_W-1:0] rd_min, rd_max, nx_min, nx_max;
    logic signed [SUM_W-1:0]  rd_sum, nx_sum;
    logic [CNT_W-1:0]         rd_cnt, nx_cnt;
    logic [AW-1:0]            raddr;
    logic signed [CELL_W-1:0] quot;
    logic                     div_done, div_busy;

    // Slot selection at the start of a tile
    assign restart   = !r_open && (r_mode == MODE_SPATIAL) && (i_tile_index > r_prev);
    assign slot_now  = restart ? '0 : r_cur;
    assign drop_now  = (slot_now >= LIMIT);
    assign fresh_now = !drop_now && (slot_now >= r_used);
    assign adv_tile  = i_last_in_tile && ((r_mode == MODE_SPATIAL) ||
                       ({1'b0, i_tile_index} == TILES_W'(i_tiles_per_raster - 1'b1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SPATIAL;
            r_cur  <= '0;
            r_prev <= '0;
            r_used <= '0;
            r_ovf  <= 1'b0;
            r_open <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_mode;
            end
            if (i_cmd.take) begin
                if (!r_open) begin
                    r_prev <= i_tile_index;
                end
                r_open <= !i_last_in_tile;
                if (drop_now) begin
                    r_ovf <= 1'b1;
                end
                if (fresh_now) begin
                    r_used <= slot_now + 1'b1;
                end
                if (adv_tile && !drop_now) begin
                    r_cur <= slot_now + 1'b1;
                end else begin
                    r_cur <= slot_now;
                end
            end
        end
    end

    // Latch the cell word
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_slot  <= slot_now;
            r_fresh <= fresh_now;
            r_drop  <= drop_now;
            r_cell  <= i_cell_value;
        end
    end

    // Slot update
    assign {rd_cnt, rd_sum, rd_max, rd_min} = rd_word;
    always_comb begin
        if (r_fresh) begin
            nx_min = r_cell;
            nx_max = r_cell;
            nx_sum = SUM_W'(r_cell);
            nx_cnt = CNT_W'(1);
        end else begin
            nx_min = (r_cell < rd_min) ? r_cell : rd_min;
            nx_max = (r_cell > rd_max) ? r_cell : rd_max;
            if (rd_cnt != '1) begin
                nx_sum = rd_sum + SUM_W'(r_cell);
                nx_cnt = rd_cnt + 1'b1;
            end else begin
                nx_sum = rd_sum;
                nx_cnt = rd_cnt;
            end
        end
    end
    assign wr_word = {nx_cnt, nx_sum, nx_max, nx_min};
    assign raddr   = i_cmd.rd_rpt ? r_k[AW-1:0] : r_slot[AW-1:0];

    rgmm_ram #(.WIDTH(WORD_W), .DEPTH(MAX_RASTERS), .AW(AW)) u_stats (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_cell && !r_drop),
        .i_waddr (r_slot[AW-1:0]),
        .i_wdata (wr_word),
        .i_raddr (raddr),
        .o_rdata (rd_word)
    );

    rgmm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (rd_sum),
        .i_divisor  (rd_cnt),
        .o_quot     (quot),
        .o_done     (div_done),
        .o_busy     (div_busy)
    );

    // Report index and latched extremes
    assign k_inc  = {1'b0, r_k} + 1'b1;
    assign k_wide = {{RN_W{1'b0}}, r_k};
    always_ff @(posedge i_clk) begin
        if (i_cmd.rpt_start) begin
            r_k <= '0;
        end else if (i_cmd.rpt_next) begin
            r_k <= k_inc[SW-1:0];
        end
        if (i_cmd.div_start) begin
            r_min <= rd_min;
            r_max <= rd_max;
        end
    end

    // Output register: load a word, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_rn   <= k_wide[RN_W-1:0];
            r_o_mean <= quot;
            r_o_max  <= r_max;
            r_o_min  <= r_min;
            r_o_last <= (k_inc == {1'b0, r_used});
            r_o_drop <= r_ovf;
        end
    end

    assign o_sts.used_zero = (r_used == '0);
    assign o_sts.rpt_last  = (k_inc == {1'b0, r_used});
    assign o_sts.div_done  = div_done;
    assign o_sts.div_busy  = div_busy;
    assign o_sts.out_free  = !r_o_valid || i_out_ready;

    assign o_out_valid     = r_o_valid;
    assign o_raster_number = r_o_rn;
    assign o_mean_value    = r_o_mean;
    assign o_maximum_value = r_o_max;
    assign o_minimum_value = r_o_min;
    assign o_last_entry    = r_o_last;
    assign o_cells_dropped = r_o_drop;
endmodule

FILE: dv/rgmm_checker.sv
// Checker for the raster group min/max/mean unit: watches the cell, config and
// statistics channels, predicts each statistics word and compares it.
// Depends on rgmm_pkg and rgmm_ifs.
module rgmm_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rgmm_in_if.sink    i_cell_mon,
    rgmm_cfg_if.sink   i_cfg_mon,
    rgmm_out_if.sink   i_stat_mon,
    output int         o_fail_count,
    output int         o_pending
);
    import rgmm_pkg::*;

    localparam int SLOTS = MAX_RASTERS_DEF;

    typedef struct packed {
        logic [RN_W-1:0]   rn;
        logic [CELL_W-1:0] mean;
        logic [CELL_W-1:0] maxv;
        logic [CELL_W-1:0] minv;
        logic              last;
        logic              dropped;
    } stat_word_t;

    logic signed [CELL_W-1:0] slot_min [SLOTS];
    logic signed [CELL_W-1:0] slot_max [SLOTS];
    logic signed [SUM_W-1:0]  slot_sum [SLOTS];
    logic [CNT_W-1:0]         slot_cnt [SLOTS];
    int unsigned              cur_slot;
    logic [TILE_W-1:0]        prev_tile;
    int unsigned              used_slots;
    logic                     overflow;
    logic                     tile_open;
    logic                     mode;
    stat_word_t               stat_queue [$];
    int                       fails;

    assign o_fail_count = fails;
    assign o_pending    = stat_queue.size();

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    // Update raster statistics for one accepted cell word, or predict the words of a report
    task automatic predict_word();
        logic signed [CELL_W-1:0] v;
        logic signed [SUM_W-1:0]  q;
        stat_word_t               w;
        v = i_cell_mon.cell_value;
        if (i_cell_mon.action == ACT_REPORT) begin
            for (int k = 0; k < used_slots; k++) begin
                q = (slot_cnt[k] == 0) ? 0 : slot_sum[k] / $signed({32'd0, slot_cnt[k]});
                w.rn = k[RN_W-1:0];
                w.mean = q[CELL_W-1:0];
                w.maxv = slot_max[k];
                w.minv = slot_min[k];
                w.last = (k + 1 == used_slots);
                w.dropped = overflow;
                stat_queue.push_back(w);
            end
            return;
        end
        if (!tile_open) begin
            if (mode == MODE_SPATIAL && i_cell_mon.tile_index > prev_tile) cur_slot = 0;
            prev_tile = i_cell_mon.tile_index;
            tile_open = 1'b1;
        end
        if (cur_slot >= SLOTS) begin
            overflow = 1'b1;
        end else if (cur_slot >= used_slots) begin
            slot_min[cur_slot] = v;
            slot_max[cur_slot] = v;
            slot_sum[cur_slot] = v;
            slot_cnt[cur_slot] = 1;
            used_slots = cur_slot + 1;
        end else begin
            if (v < slot_min[cur_slot]) slot_min[cur_slot] = v;
            if (v > slot_max[cur_slot]) slot_max[cur_slot] = v;
            if (slot_cnt[cur_slot] != '1) begin
                slot_sum[cur_slot] += v;
                slot_cnt[cur_slot]++;
            end
        end
        if (i_cell_mon.last_in_tile) begin
            tile_open = 1'b0;
            if (mode == MODE_SPATIAL ||
                {1'b0, i_cell_mon.tile_index} == i_cell_mon.tiles_per_raster - 17'd1) begin
                if (cur_slot < SLOTS) cur_slot++;
            end
        end
    endtask

    // Compare one statistics word with the oldest prediction
    task automatic check_stat();
        stat_word_t w;
        if (stat_queue.size() == 0) begin
            report_mismatch("unexpected word", i_stat_mon.raster_number, 0);
            return;
        end
        w = stat_queue.pop_front();
        if (i_stat_mon.raster_number != w.rn)
            report_mismatch("raster_number", i_stat_mon.raster_number, w.rn);
        if (i_stat_mon.mean_value != w.mean)
            report_mismatch("mean_value", i_stat_mon.mean_value, w.mean);
        if (i_stat_mon.maximum_value != w.maxv)
            report_mismatch("maximum_value", i_stat_mon.maximum_value, w.maxv);
        if (i_stat_mon.minimum_value != w.minv)
            report_mismatch("minimum_value", i_stat_mon.minimum_value, w.minv);
        if (i_stat_mon.last_entry != w.last)
            report_mismatch("last_entry", i_stat_mon.last_entry, w.last);
        if (i_stat_mon.cells_dropped != w.dropped)
            report_mismatch("cells_dropped", i_stat_mon.cells_dropped, w.dropped);
    endtask

    initial fails = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_slot   = 0;
            prev_tile  = '0;
            used_slots = 0;
            overflow   = 1'b0;
            tile_open  = 1'b0;
            mode       = MODE_SPATIAL;
            stat_queue.delete();
        end else begin
            if (i_stat_mon.valid && i_stat_mon.ready) check_stat();
            if (i_cfg_mon.valid && i_cfg_mon.ready) mode = i_cfg_mon.order_mode;
            if (i_cell_mon.valid && i_cell_mon.ready) predict_word();
        end
    end

    final begin
        if (stat_queue.size() != 0)
            $display("mismatch: %0d predicted words never came", stat_queue.size());
    end
endmodule

FILE: dv/tb_top.sv
// Testbench top for the raster group min/max/mean unit: drives cells, reports
// and order mode writes, stalls the output, and gives the verdict.
// Depends on rgmm_pkg, rgmm_ifs, rgmm_checker and the unit itself.
module tb_top;
    import rgmm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    logic hold_off;
    logic hold_req;

    rgmm_in_if  cell_ch ();
    rgmm_cfg_if cfg_ch ();
    rgmm_out_if stat_ch ();

    raster_group_min_max_mean_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cell_ch(cell_ch.sink),
        .i_cfg_ch (cfg_ch.sink),
        .o_stat_ch(stat_ch.source)
    );

    rgmm_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cell_mon  (cell_ch.sink),
        .i_cfg_mon   (cfg_ch.sink),
        .i_stat_mon  (stat_ch.sink),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Send one word after a random gap (none if no_gap) and wait until it is taken
    task automatic send_word(input logic act, input logic [15:0] tile,
                             input logic [16:0] tiles, input logic [31:0] cell_val,
                             input logic last, input bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13));
        @(negedge i_clk);
        if (gap != 0) begin
            cell_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cell_ch.valid            <= 1'b1;
        cell_ch.action           <= act;
        cell_ch.tile_index       <= tile;
        cell_ch.tiles_per_raster <= tiles;
        cell_ch.cell_value       <= cell_val;
        cell_ch.last_in_tile     <= last;
        @(posedge i_clk);
        while (!cell_ch.ready) @(posedge i_clk);
    endtask

    // Drop valid, then wait until every expected word has come
    task automatic wait_drained();
        @(negedge i_clk);
        cell_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    // Write order mode while the unit is idle
    task automatic write_mode(input logic m);
        wait_drained();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.order_mode <= m;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_cell();
        case ($urandom_range(0, 4))
            0: rand_cell = 32'h8000_0000;
            1: rand_cell = 32'h7fff_ffff;
            2: rand_cell = $urandom_range(0, 20) - 10;
            default: rand_cell = $urandom;
        endcase
    endfunction

    // One raster set: rasters x tiles, a few cells per tile
    task automatic send_set(input logic m, input int rasters, input int tiles,
                            input bit fast);
        int cells;
        if (m == MODE_SPATIAL) begin
            for (int t = 0; t < tiles; t++)
                for (int r = 0; r < rasters; r++) begin
                    cells = $urandom_range(1, 3);
                    for (int c = 0; c < cells; c++)
                        send_word(ACT_CELL, 16'(t), 17'(tiles), rand_cell(),
                                  c == cells - 1, fast);
                end
        end else begin
            for (int r = 0; r < rasters; r++)
                for (int t = 0; t < tiles; t++) begin
                    cells = $urandom_range(1, 3);
                    for (int c = 0; c < cells; c++)
                        send_word(ACT_CELL, 16'(t), 17'(tiles), rand_cell(),
                                  c == cells - 1, fast);
                end
        end
    endtask

    // Receiver stalls, with one long hold-off on request
    initial begin
        int gap;
        bit held;
        held = 1'b0;
        stat_ch.ready = 1'b0;
        hold_off = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                hold_off = 1'b1;
                stat_ch.ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_off = 1'b0;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
            if (gap == 0) begin
                stat_ch.ready <= 1'b1;
            end else begin
                stat_ch.ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    end

    // Watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if ((cell_ch.valid && cell_ch.ready) || (stat_ch.valid && stat_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready) || !i_rst_n || hold_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        hold_req = 1'b0;
        i_rst_n = 1'b0;
        cell_ch.valid = 1'b0;
        cell_ch.action = ACT_CELL;
        cell_ch.tile_index = '0;
        cell_ch.tiles_per_raster = 17'd1;
        cell_ch.cell_value = '0;
        cell_ch.last_in_tile = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.order_mode = MODE_SPATIAL;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty report, extremes, new slot, spatial restart
        send_word(ACT_REPORT, 16'hffff, 17'h1ffff, 32'hffff_ffff, 1'b1);
        send_word(ACT_CELL, 0, 2, 32'h8000_0000, 1'b0);
        send_word(ACT_CELL, 0, 2, 32'h7fff_ffff, 1'b1);
        send_word(ACT_CELL, 0, 2, 32'hffff_fffd, 1'b1);
        send_word(ACT_REPORT, 0, 2, 0, 1'b0);
        send_word(ACT_CELL, 1, 2, 32'd7, 1'b0);
        send_word(ACT_REPORT, 0, 2, 0, 1'b0);   // open tile survives a report
        send_word(ACT_CELL, 1, 2, 32'hffff_fff0, 1'b1);
        send_word(ACT_CELL, 16'hffff, 17'h10000, 32'h5555_aaaa, 1'b1);
        send_word(ACT_REPORT, 0, 0, 0, 1'b0);
        write_mode(MODE_TEMPORAL);
        // zero tiles per raster never advances the slot
        send_word(ACT_CELL, 16'hffff, 17'd0, 32'h0000_1234, 1'b1);
        send_word(ACT_CELL, 0, 17'd1, 32'hffff_0000, 1'b1);
        send_word(ACT_CELL, 0, 17'd1, 32'h1, 1'b1);
        send_word(ACT_REPORT, 0, 0, 0, 1'b0);

        // Slot overflow in temporal order, then a long receiver hold-off
        send_set(MODE_TEMPORAL, 66, 1, 1'b1);
        hold_req = 1'b1;
        send_word(ACT_REPORT, 0, 0, 0, 1'b0, 1'b1);
        for (int i = 0; i < 6; i++) send_word(ACT_CELL, 0, 1, rand_cell(), 1'b1, 1'b1);
        wait_drained();
        write_mode(MODE_SPATIAL);

        // Random well-formed sets with reports, mixed with noise words
        for (int p = 0; p < 6; p++) begin
            send_set(p[0], $urandom_range(1, 4), $urandom_range(1, 3), 1'b0);
            if ($urandom_range(0, 2) == 0)
                send_word(ACT_CELL, 16'($urandom), 17'($urandom), $urandom,
                          1'($urandom), 1'b0);
            send_word(ACT_REPORT, 16'($urandom), 17'($urandom), $urandom, 1'($urandom));
            write_mode(~p[0]);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

FILE: sim.f
hdl/rgmm_pkg.sv
hdl/rgmm_ifs.sv
hdl/rgmm_ram.sv
hdl/rgmm_div.sv
hdl/rgmm_ctrl.sv
hdl/rgmm_dp.sv
hdl/raster_group_min_max_mean_unit.sv
dv/rgmm_checker.sv
dv/tb_top.sv
